// ----- hdl/sepq_pkg.sv -----
package sepq_pkg;

   localparam int SEPQ_DEPTH  = 16;
   localparam int TIME_BITS   = 32;
   localparam int TAG_BITS    = 16;
   localparam int STATUS_BITS = 2;
   localparam int ENTRY_BITS  = 5;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_POP_EMPTY  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_PUSH_FULL  = 2'd2;

   typedef struct packed {
      logic                 opcode;
      logic [TIME_BITS-1:0] event_time;
      logic [TAG_BITS-1:0]  event_tag;
   } sepq_req_type;

   typedef struct packed {
      logic                   out_valid;
      logic [TIME_BITS-1:0]   out_time;
      logic [TAG_BITS-1:0]    out_tag;
      logic [STATUS_BITS-1:0] status;
      logic [ENTRY_BITS-1:0]  entry_total;
      logic                   is_empty;
   } sepq_rsp_type;

   typedef struct packed {
      logic                 valid;
      logic [TIME_BITS-1:0] event_time;
      logic [TAG_BITS-1:0]  event_tag;
   } slot_type;

   typedef struct packed {
      logic                 push;
      logic                 pop;
      logic [TIME_BITS-1:0] event_time;
      logic [TAG_BITS-1:0]  event_tag;
   } cell_cmd_type;

endpackage

// ----- hdl/sepq_cell.sv -----
module sepq_cell import sepq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  slot_type     left_slot,
   input  logic         left_take,
   input  slot_type     right_slot,
   output slot_type     slot,
   output logic         take
);

   logic                 valid_ff, valid_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;

   assign take = !valid_ff || (time_ff > cmd.event_time);

   always_comb begin
      valid_in = valid_ff;
      time_in  = time_ff;
      tag_in   = tag_ff;
      if (cmd.push) begin
         if (take) begin
            if (left_take) begin
               valid_in = left_slot.valid;
               time_in  = left_slot.event_time;
               tag_in   = left_slot.event_tag;
            end else begin
               valid_in = 1'b1;
               time_in  = cmd.event_time;
               tag_in   = cmd.event_tag;
            end
         end
      end else if (cmd.pop) begin
         valid_in = right_slot.valid;
         time_in  = right_slot.event_time;
         tag_in   = right_slot.event_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      tag_ff  <= tag_in;
   end

   assign slot.valid      = valid_ff;
   assign slot.event_time = time_ff;
   assign slot.event_tag  = tag_ff;

endmodule

// ----- hdl/sorted_event_priority_queue.sv -----
// Channel   Ports                         Direction   Moves
// req       req_valid req_stall req_item  in          push or pop item
// rsp       rsp_valid rsp_stall rsp_item  out         one result item per request
//
// One item per cycle while req_stall is low; each result appears in the cycle after its request is taken.
// A push compares its time against every cell at once; the row shifts in the same cycle.
// Reset empties the queue; slot contents are left as they are.
// req_stall is high while a result waits in the output register and rsp_stall is high.
module sorted_event_priority_queue import sepq_pkg::*; #(
   parameter int DEPTH = SEPQ_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  sepq_req_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output sepq_rsp_type rsp_item
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic             accept;
   logic             is_full, is_none;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sepq_rsp_type     rsp_ff, rsp_in;
   cell_cmd_type     cmd;
   slot_type         slots [DEPTH];
   logic             takes [DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_full   = (cnt_ff == CNT_W'(DEPTH));
   assign is_none   = (cnt_ff == '0);

   assign cmd.push       = accept && (req_item.opcode == OP_PUSH) && !is_full;
   assign cmd.pop        = accept && (req_item.opcode == OP_POP) && !is_none;
   assign cmd.event_time = req_item.event_time;
   assign cmd.event_tag  = req_item.event_tag;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      slot_type left_slot, right_slot;
      logic     left_take;
      if (i == 0) begin : g_head
         assign left_slot = '0;
         assign left_take = 1'b0;
      end else begin : g_body
         assign left_slot = slots[i-1];
         assign left_take = takes[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_slot = '0;
      end else begin : g_inner
         assign right_slot = slots[i+1];
      end
      sepq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_slot  (left_slot),
         .left_take  (left_take),
         .right_slot (right_slot),
         .slot       (slots[i]),
         .take       (takes[i])
      );
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.push) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in        = 1'b1;
         rsp_in.out_valid    = cmd.pop;
         rsp_in.out_time     = cmd.pop ? slots[0].event_time : '0;
         rsp_in.out_tag      = cmd.pop ? slots[0].event_tag : '0;
         rsp_in.status       = ST_OK;
         if (req_item.opcode == OP_PUSH && is_full) begin
            rsp_in.status = ST_PUSH_FULL;
         end else if (req_item.opcode == OP_POP && is_none) begin
            rsp_in.status = ST_POP_EMPTY;
         end
         rsp_in.entry_total  = ENTRY_BITS'(cnt_in);
         rsp_in.is_empty     = (cnt_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
